/* design/tcd_pkg.sv */
// ----------------------------------------------------------------------------
// tcd_pkg
// Shared types and constants of the tile cache directory.
// ----------------------------------------------------------------------------
`default_nettype none

package tcd_pkg;

    // field and store widths
    localparam int MAX_TILES = 4096;
    localparam int TILE_W    = 12;
    localparam int MAX_SLOTS = 64;
    localparam int SLOT_W    = 6;
    localparam int CNT_W     = 7;
    localparam int ADDR_W    = 22;
    localparam int EDGE_W    = 12;
    localparam int ACROSS_W  = 13;
    localparam int DIM_W     = 16;
    localparam int DATA_W    = 32;
    localparam int DIR_W     = SLOT_W + 1;
    localparam int CFG_IDX_W = 3;
    localparam int QDEPTH    = 2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TILE_EDGE    = 3'd0,
        REG_TILES_ACROSS = 3'd1,
        REG_SLOTS_IN_USE = 3'd2,
        REG_IMAGE_WIDTH  = 3'd3,
        REG_IMAGE_HEIGHT = 3'd4
    } reg_index_t;

    // effective configuration seen by front and back
    typedef struct packed {
        logic [EDGE_W-1:0]   edge_len;
        logic [ACROSS_W-1:0] across;
        logic [CNT_W-1:0]    nslots;
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
    } cfg_t;

    // classified word between front and back
    typedef struct packed {
        logic              op;
        logic [DATA_W-1:0] data;
        logic              range_err;
        logic [TILE_W-1:0] tile;
        logic [ADDR_W-1:0] offset;
    } entry_t;

    // result word
    typedef struct packed {
        logic              hit;
        logic              range_err;
        logic [ADDR_W-1:0] addr;
        logic [TILE_W-1:0] tile;
        logic [SLOT_W-1:0] slot;
        logic              evict;
        logic [TILE_W-1:0] evicted;
        logic              op;
        logic [DATA_W-1:0] data;
    } result_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_DIV,
        F_MUL,
        F_CHK,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_DEC,
        B_FILL,
        B_MUL,
        B_OUT
    } back_state_t;

endpackage

`default_nettype wire

/* design/tcd_ram.sv */
// ----------------------------------------------------------------------------
// tcd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* design/tcd_front.sv */
// ----------------------------------------------------------------------------
// tcd_front
// Takes a pixel access, splits both coordinates by the tile edge with two
// bit-serial dividers side by side, forms tile number and offset, checks range.
// ----------------------------------------------------------------------------
`default_nettype none

module tcd_front #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tcd_pkg::cfg_t                 cfg,
    input  wire logic                          in_take,
    input  wire logic                          op,
    input  wire logic [COORD_BITS-1:0]         px,
    input  wire logic [COORD_BITS-1:0]         py,
    input  wire logic [tcd_pkg::DATA_W-1:0]    wdata,
    output logic                               idle,
    output logic                               q_push,
    input  wire logic                          q_full,
    output tcd_pkg::entry_t                    q_entry
);

    localparam int CW     = COORD_BITS;
    localparam int EW     = tcd_pkg::EDGE_W;
    localparam int CNT_W  = $clog2(CW + 1);
    localparam int PROD_W = CW + tcd_pkg::ACROSS_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int CMP_W  = (CW > tcd_pkg::DIM_W) ? CW : tcd_pkg::DIM_W;

    tcd_pkg::front_state_t state_reg, state_next;

    logic [CNT_W-1:0]  cnt_reg;
    logic              op_reg;
    logic [tcd_pkg::DATA_W-1:0] data_reg;
    logic [CW-1:0]     x_reg, y_reg;
    logic [CW-1:0]     qx_reg, qy_reg;
    logic [EW:0]       rx_reg, ry_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [2*EW-1:0]   offm_reg;
    logic              oor_reg;
    tcd_pkg::entry_t   entry_reg;

    logic [EW:0]       rx_sh, ry_sh, edge_ext;
    logic              bx, by;
    logic [SUM_W-1:0]  tile_sum;
    logic [2*EW-1:0]   off_sum;

    // divider step for both coordinates
    always_comb
    begin
        edge_ext = {1'b0, cfg.edge_len};
        rx_sh    = {rx_reg[EW-1:0], qx_reg[CW-1]};
        ry_sh    = {ry_reg[EW-1:0], qy_reg[CW-1]};
        bx       = (rx_sh >= edge_ext);
        by       = (ry_sh >= edge_ext);
        tile_sum = SUM_W'(prod_reg) + SUM_W'(qx_reg);
        off_sum  = offm_reg + (2*EW)'(rx_reg[EW-1:0]);
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcd_pkg::F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == tcd_pkg::F_IDLE)
            begin
                cnt_reg <= CNT_W'(CW - 1);
            end
            else if (state_reg == tcd_pkg::F_DIV)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        q_push     = 1'b0;
        unique case (state_reg)
            tcd_pkg::F_IDLE:
            begin
                if (in_take)
                begin
                    state_next = tcd_pkg::F_DIV;
                end
            end
            tcd_pkg::F_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = tcd_pkg::F_MUL;
                end
            end
            tcd_pkg::F_MUL:
            begin
                state_next = tcd_pkg::F_CHK;
            end
            tcd_pkg::F_CHK:
            begin
                state_next = tcd_pkg::F_PUSH;
            end
            tcd_pkg::F_PUSH:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = tcd_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = tcd_pkg::F_IDLE;
            end
        endcase
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            tcd_pkg::F_IDLE:
            begin
                op_reg   <= op;
                data_reg <= wdata;
                x_reg    <= px;
                y_reg    <= py;
                qx_reg   <= px;
                qy_reg   <= py;
                rx_reg   <= '0;
                ry_reg   <= '0;
            end
            tcd_pkg::F_DIV:
            begin
                rx_reg <= bx ? (rx_sh - edge_ext) : rx_sh;
                ry_reg <= by ? (ry_sh - edge_ext) : ry_sh;
                qx_reg <= {qx_reg[CW-2:0], bx};
                qy_reg <= {qy_reg[CW-2:0], by};
            end
            tcd_pkg::F_MUL:
            begin
                prod_reg <= qy_reg * cfg.across;
                offm_reg <= ry_reg[EW-1:0] * cfg.edge_len;
                oor_reg  <= (CMP_W'(x_reg) >= CMP_W'(cfg.width))
                         || (CMP_W'(y_reg) >= CMP_W'(cfg.height));
            end
            tcd_pkg::F_CHK:
            begin
                entry_reg.op        <= op_reg;
                entry_reg.data      <= data_reg;
                entry_reg.range_err <= oor_reg
                                    || (tile_sum >= SUM_W'(tcd_pkg::MAX_TILES));
                entry_reg.tile      <= tile_sum[tcd_pkg::TILE_W-1:0];
                entry_reg.offset    <= off_sum[tcd_pkg::ADDR_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    assign idle    = (state_reg == tcd_pkg::F_IDLE);
    assign q_entry = entry_reg;

endmodule

`default_nettype wire

/* design/tcd_queue.sv */
// ----------------------------------------------------------------------------
// tcd_queue
// Short queue of classified words between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module tcd_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  wire tcd_pkg::entry_t wr_entry,
    output logic                 full,
    input  wire logic            rd_en,
    output tcd_pkg::entry_t      rd_entry,
    output logic                 empty
);

    localparam int PW = $clog2(tcd_pkg::QDEPTH);

    tcd_pkg::entry_t      slots_reg [tcd_pkg::QDEPTH];
    logic [PW-1:0]        wp_reg, rp_reg;
    logic [PW:0]          cnt_reg;

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (rd_en)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slots_reg[wp_reg] <= wr_entry;
        end
    end

    assign rd_entry = slots_reg[rp_reg];
    assign empty    = (cnt_reg == '0);
    assign full     = (cnt_reg == (PW+1)'(tcd_pkg::QDEPTH));

endmodule

`default_nettype wire

/* design/tcd_back.sv */
// ----------------------------------------------------------------------------
// tcd_back
// Directory lookup, slot allocation with round-robin replacement, eviction
// and cache word address; holds the result word until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tcd_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire tcd_pkg::cfg_t   cfg,
    input  wire logic            q_empty,
    input  wire tcd_pkg::entry_t q_entry,
    output logic                 q_pop,
    output logic                 clearing,
    output logic                 res_valid,
    input  wire logic            res_take,
    output tcd_pkg::result_t     res
);

    localparam int TW = tcd_pkg::TILE_W;
    localparam int SW = tcd_pkg::SLOT_W;
    localparam int AW = tcd_pkg::ADDR_W;
    localparam int DW = tcd_pkg::DIR_W;

    tcd_pkg::back_state_t state_reg, state_next;

    logic [TW-1:0]      clr_reg;
    logic [tcd_pkg::CNT_W-1:0] filled_reg;
    logic [SW-1:0]      ptr_reg;
    tcd_pkg::entry_t    ent_reg;
    logic [SW-1:0]      slot_reg;
    logic               hit_reg, evict_reg;
    logic [TW-1:0]      evicted_reg;
    logic [AW-1:0]      area_reg, prod_reg;
    logic               res_valid_reg;
    tcd_pkg::result_t   res_reg;

    logic               dir_we;
    logic [TW-1:0]      dir_wa;
    logic [DW-1:0]      dir_wd, dir_rd;
    logic               own_we;
    logic [TW-1:0]      own_rd;
    logic [SW-1:0]      victim, ptr_inc;
    logic               out_free;
    logic [2*tcd_pkg::EDGE_W-1:0] area_full;

    // replacement pointer, wrapped to the slot count
    always_comb
    begin
        victim   = ({1'b0, ptr_reg} >= cfg.nslots) ? '0 : ptr_reg;
        ptr_inc  = (({1'b0, victim} + 1'b1) >= cfg.nslots) ? '0 : (victim + 1'b1);
        out_free = !res_valid_reg || res_take;
        area_full = cfg.edge_len * cfg.edge_len;
    end

    tcd_ram #(
        .WIDTH (DW),
        .DEPTH (tcd_pkg::MAX_TILES)
    ) u_dir (
        .clk     (clk),
        .wr_en   (dir_we),
        .wr_addr (dir_wa),
        .wr_data (dir_wd),
        .rd_addr (q_entry.tile),
        .rd_data (dir_rd)
    );

    tcd_ram #(
        .WIDTH (TW),
        .DEPTH (tcd_pkg::MAX_SLOTS)
    ) u_owner (
        .clk     (clk),
        .wr_en   (own_we),
        .wr_addr (own_we && !dir_rd[DW-1] && (filled_reg < cfg.nslots)
                  ? filled_reg[SW-1:0] : victim),
        .wr_data (ent_reg.tile),
        .rd_addr (victim),
        .rd_data (own_rd)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcd_pkg::B_CLEAR;
            clr_reg       <= '0;
            filled_reg    <= '0;
            ptr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == tcd_pkg::B_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if ((state_reg == tcd_pkg::B_DEC) && !dir_rd[DW-1])
            begin
                if (filled_reg < cfg.nslots)
                begin
                    filled_reg <= filled_reg + 1'b1;
                end
                else
                begin
                    ptr_reg <= ptr_inc;
                end
            end
            if ((state_reg == tcd_pkg::B_OUT) && out_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_take)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // next state and store writes
    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        dir_we     = 1'b0;
        dir_wa     = ent_reg.tile;
        dir_wd     = {1'b1, slot_reg};
        own_we     = 1'b0;
        unique case (state_reg)
            tcd_pkg::B_CLEAR:
            begin
                dir_we = 1'b1;
                dir_wa = clr_reg;
                dir_wd = '0;
                if (clr_reg == '1)
                begin
                    state_next = tcd_pkg::B_IDLE;
                end
            end
            tcd_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = q_entry.range_err ? tcd_pkg::B_OUT : tcd_pkg::B_DEC;
                end
            end
            tcd_pkg::B_DEC:
            begin
                if (dir_rd[DW-1])
                begin
                    state_next = tcd_pkg::B_MUL;
                end
                else
                begin
                    own_we = 1'b1;
                    if (filled_reg >= cfg.nslots)
                    begin
                        // drop the evicted tile from the directory
                        dir_we = 1'b1;
                        dir_wa = own_rd;
                        dir_wd = '0;
                    end
                    state_next = tcd_pkg::B_FILL;
                end
            end
            tcd_pkg::B_FILL:
            begin
                dir_we     = 1'b1;
                state_next = tcd_pkg::B_MUL;
            end
            tcd_pkg::B_MUL:
            begin
                state_next = tcd_pkg::B_OUT;
            end
            tcd_pkg::B_OUT:
            begin
                if (out_free)
                begin
                    state_next = tcd_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = tcd_pkg::B_IDLE;
            end
        endcase
    end

    // datapath
    always_ff @(posedge clk)
    begin
        area_reg <= area_full[AW-1:0];
        case (state_reg)
            tcd_pkg::B_IDLE:
            begin
                ent_reg   <= q_entry;
                slot_reg  <= '0;
                hit_reg   <= 1'b0;
                evict_reg <= 1'b0;
            end
            tcd_pkg::B_DEC:
            begin
                if (dir_rd[DW-1])
                begin
                    hit_reg  <= 1'b1;
                    slot_reg <= dir_rd[SW-1:0];
                end
                else if (filled_reg < cfg.nslots)
                begin
                    slot_reg <= filled_reg[SW-1:0];
                end
                else
                begin
                    slot_reg    <= victim;
                    evict_reg   <= 1'b1;
                    evicted_reg <= own_rd;
                end
            end
            tcd_pkg::B_MUL:
            begin
                prod_reg <= AW'(slot_reg * area_reg);
            end
            tcd_pkg::B_OUT:
            begin
                if (out_free)
                begin
                    res_reg.hit       <= hit_reg;
                    res_reg.range_err <= ent_reg.range_err;
                    res_reg.addr      <= ent_reg.range_err ? '0
                                         : (prod_reg + ent_reg.offset);
                    res_reg.tile      <= ent_reg.range_err ? '0 : ent_reg.tile;
                    res_reg.slot      <= slot_reg;
                    res_reg.evict     <= evict_reg;
                    res_reg.evicted   <= evict_reg ? evicted_reg : '0;
                    res_reg.op        <= ent_reg.op;
                    res_reg.data      <= ent_reg.data;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign clearing  = (state_reg == tcd_pkg::B_CLEAR);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

/* design/fifo_tile_cache_directory.sv */
// ----------------------------------------------------------------------------
// fifo_tile_cache_directory
// Tile cache directory with first-in-first-out slot replacement.
// ----------------------------------------------------------------------------
// The front takes one pixel access at a time and holds full high until it
// has pushed that access to the queue; its bit-serial dividers split x and y
// by the tile edge together one quotient bit a cycle. The back handles one
// word at a time: an out-of-range word goes straight to the output, a hit
// passes the directory read and address multiply, and a miss adds allocation
// and the store update; it runs alongside the front through a two-word queue.
// After reset the directory is cleared one entry a cycle, all 4096 entries,
// during which full stays high; configuration writes are taken at any time.
`default_nettype none

module fifo_tile_cache_directory #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic                              operation,
    input  wire logic [COORD_BITS-1:0]             pixel_x,
    input  wire logic [COORD_BITS-1:0]             pixel_y,
    input  wire logic [tcd_pkg::DATA_W-1:0]        write_data,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic                                   hit,
    output logic                                   range_error,
    output logic [tcd_pkg::ADDR_W-1:0]             cache_word_address,
    output logic [tcd_pkg::TILE_W-1:0]             tile_number,
    output logic [tcd_pkg::SLOT_W-1:0]             target_slot,
    output logic                                   evict_valid,
    output logic [tcd_pkg::TILE_W-1:0]             evicted_tile,
    output logic                                   access_kind,
    output logic [tcd_pkg::DATA_W-1:0]             store_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [tcd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tcd_pkg::DIM_W-1:0]         cfg_data
);

    logic [tcd_pkg::EDGE_W-1:0]   edge_reg;
    logic [tcd_pkg::ACROSS_W-1:0] across_reg;
    logic [tcd_pkg::CNT_W-1:0]    nslots_reg;
    logic [tcd_pkg::DIM_W-1:0]    width_reg, height_reg;

    tcd_pkg::cfg_t    cfg;
    tcd_pkg::entry_t  f_entry, q_entry;
    tcd_pkg::result_t res;
    logic             f_idle, f_push, q_full, q_empty, q_pop, clearing, res_valid;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_reg   <= tcd_pkg::EDGE_W'(64);
            across_reg <= tcd_pkg::ACROSS_W'(64);
            nslots_reg <= tcd_pkg::CNT_W'(64);
            width_reg  <= tcd_pkg::DIM_W'(4096);
            height_reg <= tcd_pkg::DIM_W'(4096);
        end
        else if (cfg_valid)
        begin
            unique case (tcd_pkg::reg_index_t'(cfg_index))
                tcd_pkg::REG_TILE_EDGE:    edge_reg   <= cfg_data[tcd_pkg::EDGE_W-1:0];
                tcd_pkg::REG_TILES_ACROSS: across_reg <= cfg_data[tcd_pkg::ACROSS_W-1:0];
                tcd_pkg::REG_SLOTS_IN_USE: nslots_reg <= cfg_data[tcd_pkg::CNT_W-1:0];
                tcd_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                tcd_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // effective settings: zero edge acts as one, slot count clamped
    always_comb
    begin
        cfg.edge_len = (edge_reg == '0) ? tcd_pkg::EDGE_W'(1) : edge_reg;
        cfg.across   = across_reg;
        if (nslots_reg == '0)
        begin
            cfg.nslots = tcd_pkg::CNT_W'(1);
        end
        else if (nslots_reg > tcd_pkg::CNT_W'(tcd_pkg::MAX_SLOTS))
        begin
            cfg.nslots = tcd_pkg::CNT_W'(tcd_pkg::MAX_SLOTS);
        end
        else
        begin
            cfg.nslots = nslots_reg;
        end
        cfg.width  = width_reg;
        cfg.height = height_reg;
    end

    assign cfg_ready = 1'b1;
    assign full      = !f_idle || clearing;

    tcd_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .in_take (push && !full),
        .op      (operation),
        .px      (pixel_x),
        .py      (pixel_y),
        .wdata   (write_data),
        .idle    (f_idle),
        .q_push  (f_push),
        .q_full  (q_full),
        .q_entry (f_entry)
    );

    tcd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (f_push),
        .wr_entry (f_entry),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_entry (q_entry),
        .empty    (q_empty)
    );

    tcd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_empty   (q_empty),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .res_valid (res_valid),
        .res_take  (pop && res_valid),
        .res       (res)
    );

    // result ports
    assign empty              = !res_valid;
    assign hit                = res.hit;
    assign range_error        = res.range_err;
    assign cache_word_address = res.addr;
    assign tile_number        = res.tile;
    assign target_slot        = res.slot;
    assign evict_valid        = res.evict;
    assign evicted_tile       = res.evicted;
    assign access_kind        = res.op;
    assign store_data         = res.data;

endmodule

`default_nettype wire

/* tb/sv/tb_fifo_tile_cache_directory.sv */
// ----------------------------------------------------------------------------
// tb_fifo_tile_cache_directory
// Self-checking bench for the tile cache directory: a table of directed
// accesses, then random access phases under several register settings, with
// bursty input, random output stalls and a scoreboard fed by a tile predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_fifo_tile_cache_directory;

    timeunit 1ns;
    timeprecision 1ps;

    // directed row: access plus an optional hand-written expectation
    typedef struct {
        logic                       op;
        logic [tcd_pkg::DIM_W-1:0]  x;
        logic [tcd_pkg::DIM_W-1:0]  y;
        logic [tcd_pkg::DATA_W-1:0] data;
        bit                         typed;
        tcd_pkg::result_t           want;
    } access_row_t;

    // one random phase: register setting and the pixel window it draws from
    typedef struct {
        int edge_len;
        int across;
        int nslots;
        int width;
        int height;
        int win_x;
        int win_y;
        int count;
        bit no_gaps;
    } phase_t;

    logic                          clk;
    logic                          rst_n;
    logic                          push;
    logic                          full;
    logic                          operation;
    logic [tcd_pkg::DIM_W-1:0]     pixel_x;
    logic [tcd_pkg::DIM_W-1:0]     pixel_y;
    logic [tcd_pkg::DATA_W-1:0]    write_data;
    logic                          empty;
    logic                          pop;
    logic                          hit;
    logic                          range_error;
    logic [tcd_pkg::ADDR_W-1:0]    cache_word_address;
    logic [tcd_pkg::TILE_W-1:0]    tile_number;
    logic [tcd_pkg::SLOT_W-1:0]    target_slot;
    logic                          evict_valid;
    logic [tcd_pkg::TILE_W-1:0]    evicted_tile;
    logic                          access_kind;
    logic [tcd_pkg::DATA_W-1:0]    store_data;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [tcd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [tcd_pkg::DIM_W-1:0]     cfg_data;

    // register shadow
    logic [tcd_pkg::EDGE_W-1:0]    sh_edge;
    logic [tcd_pkg::ACROSS_W-1:0]  sh_across;
    logic [tcd_pkg::CNT_W-1:0]     sh_slots;
    logic [tcd_pkg::DIM_W-1:0]     sh_width;
    logic [tcd_pkg::DIM_W-1:0]     sh_height;

    // predicted directory state
    bit                   tile_resident [tcd_pkg::MAX_TILES];
    int                   tile_slot     [tcd_pkg::MAX_TILES];
    int                   slot_tile     [tcd_pkg::MAX_SLOTS];
    int                   fill_count;
    int                   victim_ptr;

    tcd_pkg::result_t     expected_results[$];
    int                   error_count;
    int                   burst_left;
    int                   pop_pct;
    int                   pop_hold;

    fifo_tile_cache_directory uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .operation(operation), .pixel_x(pixel_x), .pixel_y(pixel_y),
        .write_data(write_data), .empty(empty), .pop(pop), .hit(hit),
        .range_error(range_error), .cache_word_address(cache_word_address),
        .tile_number(tile_number), .target_slot(target_slot),
        .evict_valid(evict_valid), .evicted_tile(evicted_tile),
        .access_kind(access_kind), .store_data(store_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

    // tile lookup, allocation and fifo replacement for one access
    function automatic tcd_pkg::result_t predict_access(logic op,
                                                        logic [tcd_pkg::DIM_W-1:0] x,
                                                        logic [tcd_pkg::DIM_W-1:0] y,
                                                        logic [tcd_pkg::DATA_W-1:0] data);
        tcd_pkg::result_t r;
        longint unsigned  edge_len, ns, tx, ty, rx, ry, tile, slot;
        int               victim;
        int               old_tile;
        bit               was_hit;
        r        = '0;
        r.op     = op;
        r.data   = data;
        edge_len = (sh_edge == 0) ? 1 : sh_edge;
        ns       = (sh_slots == 0) ? 1
                 : ((sh_slots > tcd_pkg::MAX_SLOTS) ? tcd_pkg::MAX_SLOTS : sh_slots);
        tx       = x / edge_len;
        rx       = x % edge_len;
        ty       = y / edge_len;
        ry       = y % edge_len;
        tile     = ty * sh_across + tx;
        was_hit  = 1'b0;
        if (x >= sh_width || y >= sh_height || tile >= tcd_pkg::MAX_TILES)
        begin
            r.range_err = 1'b1;
            return r;
        end
        if (tile_resident[tile])
        begin
            was_hit = 1'b1;
            slot    = tile_slot[tile];
        end
        else if (fill_count < ns)
        begin
            slot       = fill_count;
            fill_count = fill_count + 1;
        end
        else
        begin
            victim = victim_ptr;
            if (victim >= ns)
                victim = 0;
            slot                    = victim;
            old_tile                = slot_tile[victim];
            r.evict                 = 1'b1;
            r.evicted               = old_tile[tcd_pkg::TILE_W-1:0];
            tile_resident[old_tile] = 1'b0;
            victim                  = victim + 1;
            if (victim >= ns)
                victim = 0;
            victim_ptr = victim;
        end
        if (!was_hit)
        begin
            tile_resident[tile] = 1'b1;
            tile_slot[tile]     = int'(slot);
            slot_tile[slot]     = int'(tile);
        end
        r.hit  = was_hit;
        r.addr = tcd_pkg::ADDR_W'((slot * edge_len * edge_len + ry * edge_len + rx)
                                  % 64'd4194304);
        r.tile = tile[tcd_pkg::TILE_W-1:0];
        r.slot = slot[tcd_pkg::SLOT_W-1:0];
        return r;
    endfunction

    // offer one access word, predict it once accepted
    task automatic send_access(logic op, logic [tcd_pkg::DIM_W-1:0] x,
                               logic [tcd_pkg::DIM_W-1:0] y,
                               logic [tcd_pkg::DATA_W-1:0] data, bit typed,
                               tcd_pkg::result_t want, bit no_gaps);
        tcd_pkg::result_t p;
        if (burst_left == 0)
        begin
            if (!no_gaps)
            begin
                push <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left = burst_left - 1;
        push       <= 1'b1;
        operation  <= op;
        pixel_x    <= x;
        pixel_y    <= y;
        write_data <= data;
        do
            @(posedge clk);
        while (full);
        p = predict_access(op, x, y, data);
        expected_results.push_back(typed ? want : p);
    endtask

    // stop sending and wait until every result has come back
    task automatic drain();
        push <= 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // write all five registers back to back
    task automatic write_registers(phase_t ph);
        int vals [5];
        vals = '{ph.edge_len, ph.across, ph.nslots, ph.width, ph.height};
        for (int i = 0; i < 5; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= tcd_pkg::CFG_IDX_W'(i);
            cfg_data  <= tcd_pkg::DIM_W'(vals[i]);
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        sh_edge   = tcd_pkg::EDGE_W'(ph.edge_len);
        sh_across = tcd_pkg::ACROSS_W'(ph.across);
        sh_slots  = tcd_pkg::CNT_W'(ph.nslots);
        sh_width  = tcd_pkg::DIM_W'(ph.width);
        sh_height = tcd_pkg::DIM_W'(ph.height);
    endtask

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            error_count = error_count + 1;
        end
    endtask

    // result side: check each popped word, stall on a changing duty pattern
    always @(posedge clk)
    begin
        tcd_pkg::result_t w;
        if (rst_n && pop && !empty)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected word, expected none actual tile %0h",
                         $time, tile_number);
                error_count = error_count + 1;
            end
            else
            begin
                w = expected_results.pop_front();
                check_field("hit", w.hit, hit);
                check_field("range_error", w.range_err, range_error);
                check_field("cache_word_address", w.addr, cache_word_address);
                check_field("tile_number", w.tile, tile_number);
                check_field("target_slot", w.slot, target_slot);
                check_field("evict_valid", w.evict, evict_valid);
                check_field("evicted_tile", w.evicted, evicted_tile);
                check_field("access_kind", w.op, access_kind);
                check_field("store_data", w.data, store_data);
            end
        end
        if (pop_hold == 0)
        begin
            case ($urandom_range(0, 3))
                0: pop_pct = 100;
                1: pop_pct = 70;
                2: pop_pct = 30;
                default: pop_pct = 5;
            endcase
            pop_hold = $urandom_range(20, 300);
        end
        pop_hold = pop_hold - 1;
        pop <= ($urandom_range(0, 99) < pop_pct);
    end

    // stimulus
    initial
    begin
        access_row_t plan [];
        phase_t      phases [];
        phase_t      ph;
        logic [tcd_pkg::DIM_W-1:0] x, y;

        rst_n      = 1'b0;
        push       = 1'b0;
        operation  = 1'b0;
        pixel_x    = '0;
        pixel_y    = '0;
        write_data = '0;
        pop        = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        error_count = 0;
        burst_left  = 0;
        pop_pct     = 100;
        pop_hold    = 0;
        sh_edge     = 64;
        sh_across   = 64;
        sh_slots    = 64;
        sh_width    = 4096;
        sh_height   = 4096;
        fill_count  = 0;
        victim_ptr  = 0;
        for (int i = 0; i < tcd_pkg::MAX_TILES; i++)
            tile_resident[i] = 1'b0;

        plan = '{
            // first access after reset fills slot 0
            '{1'b0, 16'd0, 16'd0, 32'h0, 1'b1,
              '{1'b0, 1'b0, 22'd0, 12'd0, 6'd0, 1'b0, 12'd0, 1'b0, 32'h0}},
            '{1'b1, 16'd0, 16'd0, 32'hFFFFFFFF, 1'b1,
              '{1'b1, 1'b0, 22'd0, 12'd0, 6'd0, 1'b0, 12'd0, 1'b1, 32'hFFFFFFFF}},
            // last pixel of the image, last tile
            '{1'b0, 16'd4095, 16'd4095, 32'h0, 1'b1,
              '{1'b0, 1'b0, 22'd8191, 12'd4095, 6'd1, 1'b0, 12'd0, 1'b0, 32'h0}},
            // out of range on each edge
            '{1'b0, 16'd4096, 16'd0, 32'h0, 1'b1,
              '{1'b0, 1'b1, 22'd0, 12'd0, 6'd0, 1'b0, 12'd0, 1'b0, 32'h0}},
            '{1'b1, 16'd0, 16'hFFFF, 32'h12345678, 1'b1,
              '{1'b0, 1'b1, 22'd0, 12'd0, 6'd0, 1'b0, 12'd0, 1'b1, 32'h12345678}},
            '{1'b1, 16'hFFFF, 16'hFFFF, 32'hA5A5A5A5, 1'b1,
              '{1'b0, 1'b1, 22'd0, 12'd0, 6'd0, 1'b0, 12'd0, 1'b1, 32'hA5A5A5A5}},
            '{1'b0, 16'd64, 16'd0, 32'hDEADBEEF, 1'b0, '0},
            '{1'b1, 16'd100, 16'd200, 32'h5A5A5A5A, 1'b0, '0},
            '{1'b0, 16'd4095, 16'd0, 32'h1, 1'b0, '0},
            '{1'b1, 16'd0, 16'd4095, 32'h80000000, 1'b0, '0},
            '{1'b0, 16'd63, 16'd63, 32'h7FFFFFFF, 1'b0, '0},
            '{1'b1, 16'd4095, 16'd4095, 32'h0F0F0F0F, 1'b0, '0}
        };

        // edge, across, slots, width, height, window x/y, items, no gaps
        phases = '{
            '{64, 64, 64, 4096, 4096, 1023, 511, 250, 1'b0},
            '{16, 8, 4, 128, 128, 140, 140, 200, 1'b1},
            '{1, 4096, 1, 65535, 65535, 15, 1, 150, 1'b0},
            '{0, 13, 0, 20, 20, 22, 22, 150, 1'b0},
            '{2048, 1, 127, 65535, 65535, 65535, 65535, 200, 1'b0},
            '{7, 4096, 2, 65535, 65535, 40, 2, 150, 1'b0},
            '{64, 64, 64, 4096, 4096, 1023, 1023, 200, 1'b0},
            '{64, 64, 3, 4096, 4096, 511, 255, 200, 1'b1},
            '{4095, 4096, 64, 1, 1, 2, 2, 100, 1'b0},
            '{32, 100, 40, 0, 65535, 100, 100, 50, 1'b0}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table under reset registers
        foreach (plan[i])
            send_access(plan[i].op, plan[i].x, plan[i].y, plan[i].data,
                        plan[i].typed, plan[i].want, 1'b0);
        drain();

        // random phases, registers rewritten only while idle
        foreach (phases[p])
        begin
            ph = phases[p];
            write_registers(ph);
            @(posedge clk);
            for (int n = 0; n < ph.count; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    x = tcd_pkg::DIM_W'($urandom);
                    y = tcd_pkg::DIM_W'($urandom);
                end
                else
                begin
                    x = tcd_pkg::DIM_W'($urandom_range(0, ph.win_x));
                    y = tcd_pkg::DIM_W'($urandom_range(0, ph.win_y));
                end
                send_access(1'($urandom), x, y, $urandom, 1'b0, '0, ph.no_gaps);
            end
            drain();
        end

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
design/tcd_pkg.sv
design/tcd_ram.sv
design/tcd_front.sv
design/tcd_queue.sv
design/tcd_back.sv
design/fifo_tile_cache_directory.sv
tb/sv/tb_fifo_tile_cache_directory.sv
